// ----- rtl/core/wwlt_pkg.sv -----
// Shared widths, defaults, operation codes and character codes for the word-wrap line table.
package wwlt_pkg;
	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 16;
	localparam int LNUM_W   = 10;
	localparam int COL_W    = 10;
	localparam int FLINE_W  = 10;
	localparam int LINES_W  = 11;

	localparam int DEF_MAX_LINES  = 1024;
	localparam int DEF_INDEX_BITS = 16;

	localparam logic [COL_W-1:0] RESET_COLS = COL_W'(40);

	localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd2;
	localparam logic [OP_W-1:0] OP_CARET  = 3'd3;
	localparam logic [OP_W-1:0] OP_SPAN   = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
endpackage

// ----- rtl/core/wwlt_in_if.sv -----
// Input channel: valid/ready with one command beat.
interface wwlt_in_if;
	import wwlt_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [CHAR_W-1:0]   char_code;
	logic [IDX_W-1:0]    text_index;
	logic [LNUM_W-1:0]   line_number;
	logic [COL_W-1:0]    column_number;
	modport source (output valid, op, char_code, text_index, line_number, column_number,
		input ready);
	modport sink (input valid, op, char_code, text_index, line_number, column_number,
		output ready);
endinterface

// ----- rtl/core/wwlt_out_if.sv -----
// Result channel: valid/ready with one result beat.
interface wwlt_out_if;
	import wwlt_pkg::*;
	logic                valid;
	logic                ready;
	logic [FLINE_W-1:0]  found_line;
	logic [IDX_W-1:0]    found_column;
	logic [IDX_W-1:0]    position;
	logic [IDX_W-1:0]    span_end;
	logic [LINES_W-1:0]  lines_in_use;
	logic                text_cut;
	modport source (output valid, found_line, found_column, position, span_end,
		lines_in_use, text_cut, input ready);
	modport sink (input valid, found_line, found_column, position, span_end,
		lines_in_use, text_cut, output ready);
endinterface

// ----- rtl/core/wwlt_line_mem.sv -----
// Line start and hard-break memories, one write and one registered read each.
module wwlt_line_mem #(
	parameter int MAX_LINES  = wwlt_pkg::DEF_MAX_LINES,
	parameter int INDEX_BITS = wwlt_pkg::DEF_INDEX_BITS
) (
	input  logic                          clk,
	input  logic                          start_we,
	input  logic [$clog2(MAX_LINES)-1:0]  start_waddr,
	input  logic [INDEX_BITS-1:0]         start_wdata,
	input  logic [$clog2(MAX_LINES)-1:0]  start_raddr,
	output logic [INDEX_BITS-1:0]         start_rdata,
	input  logic                          hard_we,
	input  logic [$clog2(MAX_LINES)-1:0]  hard_waddr,
	input  logic                          hard_wdata,
	input  logic [$clog2(MAX_LINES)-1:0]  hard_raddr,
	output logic                          hard_rdata
);
	localparam int LB = $clog2(MAX_LINES);

	logic [INDEX_BITS-1:0] start_mem [MAX_LINES];
	logic                  hard_mem  [MAX_LINES];
	logic [INDEX_BITS-1:0] start_q;
	logic                  zero_q;

	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[start_waddr] <= start_wdata;
		end
		start_q <= start_mem[start_raddr];
		zero_q  <= (start_raddr == LB'(0));
	end

	always_ff @(posedge clk) begin
		if (hard_we) begin
			hard_mem[hard_waddr] <= hard_wdata;
		end
		hard_rdata <= hard_mem[hard_raddr];
	end

	// line 0 always starts at index 0 and is never written
	assign start_rdata = zero_q ? '0 : start_q;
endmodule

// ----- rtl/core/word_wrap_line_table_top.sv -----
// Word-wrap line table: command decode, wrap state, search and span sequencer.
// Begin, append and unknown ops give their result in the cycle after the accept beat.
// Locate: a binary search in the SRCH and CMP states, one memory read per halving; direct if past the text.
// Caret and span: states SPA, SPB and SPC, two reads of the line start memory.
// One item at a time; a new beat is taken once the result register is empty or being taken.
// Reset clears all control state at once; memories need no clearing pass.
module word_wrap_line_table_top #(
	parameter int MAX_LINES  = wwlt_pkg::DEF_MAX_LINES,
	parameter int INDEX_BITS = wwlt_pkg::DEF_INDEX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	wwlt_in_if.sink                      in_ch,
	wwlt_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [wwlt_pkg::COL_W-1:0]   cfg_wdata
);
	import wwlt_pkg::*;

	localparam int LB  = $clog2(MAX_LINES);
	localparam int LTW = LB + 1;
	localparam int IB  = INDEX_BITS;
	localparam int CW  = ((IB > IDX_W) ? IB : IDX_W) + 2;
	localparam int LNW = ((LTW > LNUM_W) ? LTW : LNUM_W) + 1;
	localparam logic [IB-1:0] IMAX = {IB{1'b1}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_SPA  = 3'd3;
	localparam logic [2:0] ST_SPB  = 3'd4;
	localparam logic [2:0] ST_SPC  = 3'd5;

	logic [2:0]        state_q;
	logic [COL_W-1:0]  wrap_q, cols_q;
	logic [LTW-1:0]    lt_q;
	logic [IB-1:0]     len_q, cls_q, lsp_q;
	logic              seen_q, cut_q;
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [COL_W-1:0]  col_q;
	logic [LB-1:0]     ln_q, lo_q, hi_q, mid_q;
	logic [IB-1:0]     lo_st_q, st_q;

	logic              ov_q;
	logic [FLINE_W-1:0] o_line_q;
	logic [IDX_W-1:0]  o_col_q, o_pos_q, o_end_q;
	logic [LINES_W-1:0] o_lines_q;
	logic              o_cut_q;

	logic                  start_we, hard_we;
	logic [LB-1:0]         start_waddr, hard_waddr, start_raddr;
	logic [IB-1:0]         start_wdata, start_rdata;
	logic                  hard_rdata;

	wwlt_line_mem #(.MAX_LINES(MAX_LINES), .INDEX_BITS(INDEX_BITS)) u_mem (
		.clk        (clk),
		.start_we   (start_we),
		.start_waddr(start_waddr),
		.start_wdata(start_wdata),
		.start_raddr(start_raddr),
		.start_rdata(start_rdata),
		.hard_we    (hard_we),
		.hard_waddr (hard_waddr),
		.hard_wdata (in_ch.char_code == CHAR_NL),
		.hard_raddr (ln_q),
		.hard_rdata (hard_rdata)
	);

	logic accept;
	assign in_ch.ready = (state_q == ST_IDLE) && (!ov_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;

	// append: next wrap state
	logic [COL_W-1:0] wrap_eff, cols_use;
	logic [IB-1:0]    len_n, brk;
	logic [CW-1:0]    run;
	logic             do_open, do_cut_a, is_sp;
	always_comb begin
		wrap_eff = (wrap_q == '0) ? COL_W'(1) : wrap_q;
		cols_use = (len_q == '0) ? wrap_eff : cols_q;
		len_n    = len_q + IB'(1);
		run      = CW'(len_n) - CW'(cls_q);
		brk      = seen_q ? lsp_q + IB'(1) : IB'(CW'(cls_q) + CW'(cols_use));
		is_sp    = (in_ch.char_code == CHAR_SPACE);
		do_open  = 1'b0;
		do_cut_a = 1'b0;
		if (len_q >= IMAX) begin
			do_cut_a = 1'b1;
		end else if (lt_q >= LTW'(MAX_LINES)) begin
			do_cut_a = 1'b1;
		end else if (in_ch.char_code == CHAR_NL) begin
			do_open = 1'b1;
		end else if (run > CW'(cols_use)) begin
			do_open  = 1'b1;
			do_cut_a = (lt_q + LTW'(1)) >= LTW'(MAX_LINES);
		end
	end

	logic app;
	assign app         = accept && (in_ch.op == OP_APPEND);
	assign start_we    = app && do_open;
	assign hard_we     = app && do_open;
	assign start_waddr = LB'(lt_q);
	assign hard_waddr  = LB'(lt_q - LTW'(1));
	assign start_wdata = (in_ch.char_code == CHAR_NL) ? len_n : brk;

	logic [LTW-1:0] mid_w;
	assign mid_w = (LTW'(lo_q) + LTW'(hi_q) + LTW'(1)) >> 1;

	always_comb begin
		case (state_q)
			ST_SRCH: start_raddr = LB'(mid_w);
			ST_SPB:  start_raddr = ln_q + LB'(1);
			default: start_raddr = ln_q;
		endcase
	end

	// clamp of the requested line
	logic [LB-1:0] ln_clamp;
	assign ln_clamp = (LNW'(in_ch.line_number) >= LNW'(lt_q))
		? LB'(lt_q - LTW'(1)) : LB'(in_ch.line_number);

	// span end and caret
	logic [CW-1:0] en_w, st_w, tgt_w, pos_w;
	always_comb begin
		st_w = CW'(st_q);
		if (LTW'(ln_q) + LTW'(1) < lt_q) begin
			en_w = hard_rdata ? CW'(start_rdata) - CW'(1) : CW'(start_rdata);
		end else begin
			en_w = CW'(len_q);
		end
		tgt_w = st_w + CW'(col_q);
		pos_w = en_w;
		if (en_w > st_w && (en_w - st_w) > CW'(cols_q)) begin
			pos_w = st_w + CW'(cols_q);
		end
		if (tgt_w <= pos_w) begin
			pos_w = tgt_w;
		end
	end

	logic [CW-1:0] fcol_w;
	assign fcol_w = (CW'(idx_q) >= CW'(lo_st_q)) ? CW'(idx_q) - CW'(lo_st_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wrap_q  <= RESET_COLS;
			cols_q  <= RESET_COLS;
			lt_q    <= LTW'(1);
			len_q   <= '0;
			cls_q   <= '0;
			lsp_q   <= '0;
			seen_q  <= 1'b0;
			cut_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				wrap_q <= cfg_wdata;
			end
			if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= in_ch.op;
						idx_q <= in_ch.text_index;
						col_q <= in_ch.column_number;
						ln_q  <= ln_clamp;
						o_line_q <= '0;
						o_col_q  <= '0;
						o_pos_q  <= '0;
						o_end_q  <= '0;
						o_lines_q <= LINES_W'(lt_q);
						o_cut_q   <= cut_q;
						case (in_ch.op) inside
							OP_BEGIN: begin
								cols_q <= wrap_eff;
								lt_q   <= LTW'(1);
								len_q  <= '0;
								cls_q  <= '0;
								lsp_q  <= '0;
								seen_q <= 1'b0;
								cut_q  <= 1'b0;
								o_lines_q <= LINES_W'(1);
								o_cut_q   <= 1'b0;
								ov_q <= 1'b1;
							end
							OP_APPEND: begin
								if (len_q < IMAX) begin
									len_q  <= len_n;
									cols_q <= cols_use;
								end
								if (do_cut_a) begin
									cut_q   <= 1'b1;
									o_cut_q <= 1'b1;
								end
								if (do_open) begin
									lt_q      <= lt_q + LTW'(1);
									cls_q     <= start_wdata;
									seen_q    <= 1'b0;
									o_lines_q <= LINES_W'(lt_q + LTW'(1));
								end
								if (len_q < IMAX && lt_q < LTW'(MAX_LINES)
									&& in_ch.char_code != CHAR_NL && is_sp) begin
									lsp_q  <= len_q;
									seen_q <= 1'b1;
								end
								ov_q <= 1'b1;
							end
							OP_LOCATE: begin
								if (CW'(in_ch.text_index) >= CW'(len_q)) begin
									o_line_q <= FLINE_W'(lt_q - LTW'(1));
									o_col_q  <= (CW'(in_ch.text_index) >= CW'(cls_q))
										? IDX_W'(CW'(in_ch.text_index) - CW'(cls_q)) : '0;
									ov_q <= 1'b1;
								end else begin
									lo_q    <= '0;
									hi_q    <= LB'(lt_q - LTW'(1));
									lo_st_q <= '0;
									state_q <= ST_SRCH;
								end
							end
							OP_CARET, OP_SPAN: state_q <= ST_SPA;
							default: ov_q <= 1'b1;
						endcase
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= LB'(mid_w);
						state_q <= ST_CMP;
					end else begin
						o_line_q <= FLINE_W'(lo_q);
						o_col_q  <= IDX_W'(fcol_w);
						ov_q     <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_CMP: begin
					if (CW'(start_rdata) <= CW'(idx_q)) begin
						lo_q    <= mid_q;
						lo_st_q <= start_rdata;
					end else begin
						hi_q <= mid_q - LB'(1);
					end
					state_q <= ST_SRCH;
				end
				ST_SPA: state_q <= ST_SPB;
				ST_SPB: begin
					st_q    <= start_rdata;
					state_q <= ST_SPC;
				end
				ST_SPC: begin
					o_line_q <= FLINE_W'(ln_q);
					if (op_q == OP_SPAN) begin
						o_pos_q <= IDX_W'(st_q);
						o_end_q <= IDX_W'(en_w);
					end else begin
						o_pos_q <= IDX_W'(pos_w);
					end
					ov_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.found_line   = o_line_q;
	assign out_ch.found_column = o_col_q;
	assign out_ch.position     = o_pos_q;
	assign out_ch.span_end     = o_end_q;
	assign out_ch.lines_in_use = o_lines_q;
	assign out_ch.text_cut     = o_cut_q;

`ifndef NO_ASSERTIONS
	a_lines_range: assert property (@(posedge clk) disable iff (!arst_n)
		lt_q >= LTW'(1) && lt_q <= LTW'(MAX_LINES))
		else $error("line count out of range");
	a_start_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cls_q <= len_q)
		else $error("current line start beyond text");
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		app && len_q < IMAX |=> len_q == $past(len_q) + IB'(1))
		else $error("append did not advance text length");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready)
		else $error("beat taken during a search or span");
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> lo_q < mid_q && mid_q <= hi_q)
		else $error("search midpoint outside bounds");
`endif
endmodule
